// ===== rtl/uf2_sector_write_classifier_top_assert.svh =====
// Assertion macros shared by the sector write classifier modules.
// Included by modules that check their own control logic; no other dependencies.
`ifndef UF2_SECTOR_WRITE_CLASSIFIER_TOP_ASSERT_SVH
`define UF2_SECTOR_WRITE_CLASSIFIER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define UF2SW_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define UF2SW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/uf2sw_pkg.sv =====
// Package for the sector write classifier: constants, op and verdict codes,
// and the queue entry and result structs. No dependencies.
package uf2sw_pkg;

    localparam logic [31:0] MAGIC_START_A   = 32'h0A32_4655;
    localparam logic [31:0] MAGIC_START_B   = 32'h9E5D_5157;
    localparam logic [31:0] MAGIC_FINAL     = 32'h0AB1_6F30;
    localparam logic [31:0] FLAGS_EXPECTED  = 32'h0000_2000;
    localparam logic [31:0] FAMILY_EXPECTED = 32'h5A18_069B;

    localparam logic [15:0] DISK_SIZE_RESET = 16'd8192;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 184;

    // word positions with a meaning of their own
    localparam logic [6:0] POS_START_A  = 7'd0;
    localparam logic [6:0] POS_START_B  = 7'd1;
    localparam logic [6:0] POS_FLAGS    = 7'd2;
    localparam logic [6:0] POS_TARGET   = 7'd3;
    localparam logic [6:0] POS_SIZE     = 7'd4;
    localparam logic [6:0] POS_FAMILY   = 7'd7;
    localparam logic [6:0] POS_PAYLOAD  = 7'd8;
    localparam logic [6:0] POS_LAST     = 7'd127;

    typedef enum logic [3:0] {
        OP_START_A,
        OP_START_B,
        OP_FLAGS,
        OP_TARGET,
        OP_SIZE,
        OP_FAMILY,
        OP_SKIP,
        OP_PAYLOAD,
        OP_FINAL,
        OP_FLASH
    } op_t;

    typedef enum logic [2:0] {
        VERDICT_TAKEN    = 3'd0,
        VERDICT_IGNORED  = 3'd1,
        VERDICT_REJECTED = 3'd2,
        VERDICT_ACCEPTED = 3'd3,
        VERDICT_FLASHED  = 3'd4,
        VERDICT_FAILED   = 3'd5
    } verdict_t;

    // one classified item between front and back
    typedef struct packed {
        op_t         op;
        logic [31:0] word;
        logic [6:0]  pidx;
        logic        in_area;  // start word: address inside data area
        logic        match;    // magic compare, or flash_ok for flash done
    } entry_t;

    typedef struct packed {
        verdict_t    verdict;
        logic        payload_valid;
        logic [6:0]  payload_index;
        logic [31:0] payload_data;
        logic [31:0] write_addr;
        logic [31:0] write_len;
        logic [15:0] count_accepted;
        logic [15:0] count_rejected;
        logic [15:0] count_ignored;
        logic [15:0] count_flashed;
        logic [15:0] count_failed;
    } result_t;

endpackage

// ===== rtl/uf2sw_front.sv =====
// Front end: holds the disk size register, accepts input items and classifies
// them into queue entries. Depends on uf2sw_pkg.
module uf2sw_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [15:0]                      cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [uf2sw_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,
    input  logic                             q_ready,
    output logic                             q_push,
    output uf2sw_pkg::entry_t                q_entry
);
    import uf2sw_pkg::*;

    logic [15:0] disk_size_reg;
    logic [15:0] disk_size_next;
    logic [15:0] sector_addr;
    logic [6:0]  word_pos;
    logic [31:0] sector_word;
    logic        flash_ok;
    logic [8:0]  area_lo;

    assign cfg_ready = 1'b1;

    always_comb begin
        disk_size_next = disk_size_reg;
        if (cfg_valid) begin
            disk_size_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_size_reg <= DISK_SIZE_RESET;
        end else begin
            disk_size_reg <= disk_size_next;
        end
    end

    assign sector_addr = s_tdata[15:0];
    assign word_pos    = s_tdata[22:16];
    assign sector_word = s_tdata[54:23];
    assign flash_ok    = s_tdata[55];

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready;

    // data area is [2 + total/256, total), no wrap
    assign area_lo = 9'd2 + {1'b0, disk_size_reg[15:8]};

    always_comb begin
        q_entry         = '0;
        q_entry.op      = OP_SKIP;
        q_entry.word    = sector_word;
        q_entry.pidx    = word_pos - POS_PAYLOAD;
        q_entry.in_area = (sector_addr >= {7'd0, area_lo}) &&
                          (sector_addr < disk_size_reg);
        if (s_tuser) begin
            q_entry.op    = OP_FLASH;
            q_entry.match = flash_ok;
        end else if (word_pos == POS_LAST) begin
            q_entry.op    = OP_FINAL;
            q_entry.match = (sector_word == MAGIC_FINAL);
        end else if (word_pos >= POS_PAYLOAD) begin
            q_entry.op = OP_PAYLOAD;
        end else begin
            case (word_pos)
                POS_START_A: begin
                    q_entry.op    = OP_START_A;
                    q_entry.match = (sector_word == MAGIC_START_A);
                end
                POS_START_B: begin
                    q_entry.op    = OP_START_B;
                    q_entry.match = (sector_word == MAGIC_START_B);
                end
                POS_FLAGS:  q_entry.op = OP_FLAGS;
                POS_TARGET: q_entry.op = OP_TARGET;
                POS_SIZE:   q_entry.op = OP_SIZE;
                POS_FAMILY: q_entry.op = OP_FAMILY;
                default:    q_entry.op = OP_SKIP;
            endcase
        end
    end

endmodule

// ===== rtl/uf2sw_queue.sv =====
// Short FIFO of classified items between front and back end.
// Depends on uf2sw_pkg and the assertion macro header.
`include "uf2_sector_write_classifier_top_assert.svh"
module uf2sw_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  uf2sw_pkg::entry_t push_entry,
    output logic              push_ready,
    output logic              pop_valid,
    output uf2sw_pkg::entry_t pop_entry,
    input  logic              pop
);
    import uf2sw_pkg::*;

    entry_t                 slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    assign push_ready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `UF2SW_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH), "queue count over depth")
    `UF2SW_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop,
        count_reg == $past(count_reg) + 1'b1, "queue count missed a push")
    `UF2SW_ASSERT_NOW(a_ptr_gap, aclk, aresetn, 1'b1,
        (wr_ptr_reg - rd_ptr_reg) == count_reg[QUEUE_PTR_W-1:0],
        "queue pointers disagree with count")

endmodule

// ===== rtl/uf2sw_back.sv =====
// Back end: keeps the latched header state and counters, turns each queued
// item into a result and holds it in the output register. Depends on
// uf2sw_pkg and the assertion macro header.
`include "uf2_sector_write_classifier_top_assert.svh"
module uf2sw_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             q_valid,
    input  uf2sw_pkg::entry_t                q_entry,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [uf2sw_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [7:0]                       m_tuser
);
    import uf2sw_pkg::*;

    logic        in_area_reg,  in_area_next;
    logic        magic_reg,    magic_next;
    logic [31:0] flags_reg,    flags_next;
    logic [31:0] family_reg,   family_next;
    logic [31:0] target_reg,   target_next;
    logic [31:0] size_reg,     size_next;
    logic [15:0] acc_cnt_reg,  acc_cnt_next;
    logic [15:0] rej_cnt_reg,  rej_cnt_next;
    logic [15:0] ign_cnt_reg,  ign_cnt_next;
    logic [15:0] fla_cnt_reg,  fla_cnt_next;
    logic [15:0] fai_cnt_reg,  fai_cnt_next;
    logic        out_valid_reg, out_valid_next;
    result_t     out_res_reg,   out_res_next;
    result_t     res;

    // output slot frees up when taken, so a new item can move in the same cycle
    assign q_pop = q_valid && (!out_valid_reg || m_tready);

    always_comb begin
        in_area_next = in_area_reg;
        magic_next   = magic_reg;
        flags_next   = flags_reg;
        family_next  = family_reg;
        target_next  = target_reg;
        size_next    = size_reg;
        acc_cnt_next = acc_cnt_reg;
        rej_cnt_next = rej_cnt_reg;
        ign_cnt_next = ign_cnt_reg;
        fla_cnt_next = fla_cnt_reg;
        fai_cnt_next = fai_cnt_reg;
        res          = '0;
        res.verdict  = VERDICT_TAKEN;

        case (q_entry.op)
            OP_FLASH: begin
                if (q_entry.match) begin
                    res.verdict  = VERDICT_FLASHED;
                    fla_cnt_next = fla_cnt_reg + 16'd1;
                end else begin
                    res.verdict  = VERDICT_FAILED;
                    fai_cnt_next = fai_cnt_reg + 16'd1;
                end
            end
            OP_FINAL: begin
                if (!in_area_reg || !(magic_reg && q_entry.match)) begin
                    res.verdict  = VERDICT_IGNORED;
                    ign_cnt_next = ign_cnt_reg + 16'd1;
                end else if (flags_reg != FLAGS_EXPECTED ||
                             family_reg != FAMILY_EXPECTED) begin
                    res.verdict  = VERDICT_REJECTED;
                    rej_cnt_next = rej_cnt_reg + 16'd1;
                end else begin
                    res.verdict    = VERDICT_ACCEPTED;
                    res.write_addr = target_reg;
                    res.write_len  = size_reg;
                    acc_cnt_next   = acc_cnt_reg + 16'd1;
                end
            end
            OP_PAYLOAD: begin
                res.payload_valid = 1'b1;
                res.payload_index = q_entry.pidx;
                res.payload_data  = q_entry.word;
            end
            OP_START_A: begin
                in_area_next = q_entry.in_area;
                magic_next   = q_entry.match;
            end
            OP_START_B: magic_next  = magic_reg && q_entry.match;
            OP_FLAGS:   flags_next  = q_entry.word;
            OP_TARGET:  target_next = q_entry.word;
            OP_SIZE:    size_next   = q_entry.word;
            OP_FAMILY:  family_next = q_entry.word;
            default: begin
            end
        endcase

        res.count_accepted = acc_cnt_next;
        res.count_rejected = rej_cnt_next;
        res.count_ignored  = ign_cnt_next;
        res.count_flashed  = fla_cnt_next;
        res.count_failed   = fai_cnt_next;

        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (q_pop) begin
            out_valid_next = 1'b1;
            out_res_next   = res;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_area_reg   <= 1'b0;
            magic_reg     <= 1'b0;
            flags_reg     <= '0;
            family_reg    <= '0;
            target_reg    <= '0;
            size_reg      <= '0;
            acc_cnt_reg   <= '0;
            rej_cnt_reg   <= '0;
            ign_cnt_reg   <= '0;
            fla_cnt_reg   <= '0;
            fai_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (q_pop) begin
                in_area_reg <= in_area_next;
                magic_reg   <= magic_next;
                flags_reg   <= flags_next;
                family_reg  <= family_next;
                target_reg  <= target_next;
                size_reg    <= size_next;
                acc_cnt_reg <= acc_cnt_next;
                rej_cnt_reg <= rej_cnt_next;
                ign_cnt_reg <= ign_cnt_next;
                fla_cnt_reg <= fla_cnt_next;
                fai_cnt_reg <= fai_cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg <= out_res_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {5'd0, out_res_reg.verdict};
    assign m_tdata  = {out_res_reg.count_failed,
                       out_res_reg.count_flashed,
                       out_res_reg.count_ignored,
                       out_res_reg.count_rejected,
                       out_res_reg.count_accepted,
                       out_res_reg.write_len,
                       out_res_reg.write_addr,
                       out_res_reg.payload_data,
                       out_res_reg.payload_index,
                       out_res_reg.payload_valid};

    `UF2SW_ASSERT_NEXT(a_counters_hold, aclk, aresetn, !q_pop,
        $stable(acc_cnt_reg) && $stable(rej_cnt_reg) && $stable(ign_cnt_reg) &&
        $stable(fla_cnt_reg) && $stable(fai_cnt_reg),
        "counter moved without an item")
    `UF2SW_ASSERT_NOW(a_write_only_accepted, aclk, aresetn,
        out_valid_reg && (out_res_reg.verdict != VERDICT_ACCEPTED),
        (out_res_reg.write_addr == '0) && (out_res_reg.write_len == '0),
        "write fields set on a non-accepted result")
    `UF2SW_ASSERT_NOW(a_payload_is_taken, aclk, aresetn,
        out_valid_reg && out_res_reg.payload_valid,
        out_res_reg.verdict == VERDICT_TAKEN,
        "payload word carries a sector verdict")

endmodule

// ===== rtl/uf2_sector_write_classifier_top.sv =====
// Top level of the sector write classifier: front end, item queue, back end.
// Depends on uf2sw_pkg, uf2sw_front, uf2sw_queue and uf2sw_back.
//
//  Channel   | Direction | Handshake           | Carries
//  ----------+-----------+---------------------+------------------------------------
//  cfg       | in        | cfg_valid/cfg_ready | disk size write (16 bit)
//  s_ (in)   | in        | s_tvalid/s_tready   | sector word or flash-done item
//  m_ (out)  | out       | m_tvalid/m_tready   | one result per input item
//
// Every input item gives exactly one result; an item goes front -> queue ->
// back -> output register, and is held in a queue slot, then in the output
// register; the block sustains one item per clock while m_tready is high.
// aresetn is synchronous, active low; it clears the queue, header state,
// counters and output valid, and loads the disk size with 8192.
// A stalled output holds its result while the 4-entry queue keeps taking
// items; s_tready drops only when the queue is full. cfg_ready is always high;
// the user writes the disk size only while idle; the block does not enforce it.
module uf2_sector_write_classifier_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration: disk size in sectors
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [15:0]                      cfg_data,
    // input items
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] sector_addr, [22:16] word_pos, [54:23] sector_word, [55] flash_ok
    input  logic [uf2sw_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] command (0 sector word, 1 flash done)
    input  logic                             s_tuser,
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] payload_valid, [7:1] payload_index, [39:8] payload_data,
    // [71:40] write_addr, [103:72] write_len, [119:104] count_accepted,
    // [135:120] count_rejected, [151:136] count_ignored,
    // [167:152] count_flashed, [183:168] count_failed
    output logic [uf2sw_pkg::M_TDATA_W-1:0]  m_tdata,
    // [2:0] verdict, [7:3] zero
    output logic [7:0]                       m_tuser
);
    import uf2sw_pkg::*;

    logic   push;
    logic   push_ready;
    entry_t push_entry;
    logic   pop;
    logic   pop_valid;
    entry_t pop_entry;

    // front: disk size register, per-item decode and compares
    uf2sw_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_ready   (push_ready),
        .q_push    (push),
        .q_entry   (push_entry)
    );

    // decouples acceptance from output backpressure
    uf2sw_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_entry  (pop_entry),
        .pop        (pop)
    );

    // back: header latches, sector verdict, counters, output register
    uf2sw_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (pop_valid),
        .q_entry  (pop_entry),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for uf2_sector_write_classifier_top: directed table, then random
// sectors over several disk sizes, each result checked against an in-bench classifier.
// Depends on uf2sw_pkg and the RTL of the block; reads no files.
`timescale 1ns / 100ps

module tb_top;
    import uf2sw_pkg::*;

    localparam logic CMD_WORD  = 1'b0;
    localparam logic CMD_FLASH = 1'b1;
    localparam logic CHECK     = 1'b1;
    localparam logic NO_CHECK  = 1'b0;
    localparam int   DRAIN_CYCLES = 4;    // front, queue, back, output register
    localparam int   PHASE_ITEMS  = 100;
    localparam int   NUM_PHASES   = 6;

    // one input item; has_verdict marks table rows with a typed-in verdict
    typedef struct packed {
        logic        cmd;
        logic [15:0] addr;
        logic [6:0]  pos;
        logic [31:0] word;
        logic        ok;
        logic        has_verdict;
        verdict_t    verdict;
    } sector_item_t;

    typedef logic [10:0][31:0] field_set_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [15:0]            cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [7:0]             m_tuser;

    // classifier state kept by the bench
    logic [15:0] sectors_cfg = DISK_SIZE_RESET;
    logic        area_hit = 1'b0;
    logic        magic_ok = 1'b0;
    logic [31:0] flags_q = '0;
    logic [31:0] family_q = '0;
    logic [31:0] target_q = '0;
    logic [31:0] size_q = '0;
    logic [15:0] cnt_accepted = '0;
    logic [15:0] cnt_rejected = '0;
    logic [15:0] cnt_ignored = '0;
    logic [15:0] cnt_flashed = '0;
    logic [15:0] cnt_failed = '0;

    result_t pending_results [$];

    int unsigned error_count = 0;
    int unsigned items_sent = 0;
    int unsigned results_checked = 0;
    int unsigned cfg_writes = 0;
    int unsigned seen_accepted = 0;
    int unsigned seen_rejected = 0;
    int unsigned seen_ignored = 0;
    int unsigned seen_flash = 0;
    bit          send_steady = 1'b0;
    bit          recv_steady = 1'b0;

    uf2_sector_write_classifier_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic sector_item_t make_item(logic cmd, logic [15:0] addr, logic [6:0] pos,
                                               logic [31:0] word, logic ok, logic has_verdict,
                                               verdict_t verdict);
        sector_item_t it;
        it.cmd = cmd;
        it.addr = addr;
        it.pos = pos;
        it.word = word;
        it.ok = ok;
        it.has_verdict = has_verdict;
        it.verdict = verdict;
        return it;
    endfunction

    // Expected result of one item; updates the bench's copy of the header state
    // and counters exactly as the block does.
    function automatic result_t classify_item(sector_item_t it);
        result_t r;
        int      area_lo;
        r = '0;
        r.verdict = VERDICT_TAKEN;
        if (it.cmd == CMD_FLASH) begin
            // flash done counts whether or not a write is pending
            if (it.ok) begin
                r.verdict = VERDICT_FLASHED;
                cnt_flashed = cnt_flashed + 16'd1;
            end else begin
                r.verdict = VERDICT_FAILED;
                cnt_failed = cnt_failed + 16'd1;
            end
        end else if (it.pos == POS_LAST) begin
            if (!area_hit || !(magic_ok && it.word == MAGIC_FINAL)) begin
                r.verdict = VERDICT_IGNORED;
                cnt_ignored = cnt_ignored + 16'd1;
            end else if (flags_q != FLAGS_EXPECTED || family_q != FAMILY_EXPECTED) begin
                r.verdict = VERDICT_REJECTED;
                cnt_rejected = cnt_rejected + 16'd1;
            end else begin
                r.verdict = VERDICT_ACCEPTED;
                r.write_addr = target_q;
                r.write_len = size_q;
                cnt_accepted = cnt_accepted + 16'd1;
            end
        end else if (it.pos >= POS_PAYLOAD) begin
            r.payload_valid = 1'b1;
            r.payload_index = it.pos - POS_PAYLOAD;
            r.payload_data = it.word;
        end else begin
            case (it.pos)
                POS_START_A: begin
                    // data area bounds without wrap; empty when size is tiny
                    area_lo = 2 + (sectors_cfg >> 8);
                    area_hit = (it.addr >= area_lo) && (it.addr < sectors_cfg);
                    magic_ok = (it.word == MAGIC_START_A);
                end
                POS_START_B: magic_ok = magic_ok && (it.word == MAGIC_START_B);
                POS_FLAGS:   flags_q = it.word;
                POS_TARGET:  target_q = it.word;
                POS_SIZE:    size_q = it.word;
                POS_FAMILY:  family_q = it.word;
                default: ;
            endcase
        end
        r.count_accepted = cnt_accepted;
        r.count_rejected = cnt_rejected;
        r.count_ignored = cnt_ignored;
        r.count_flashed = cnt_flashed;
        r.count_failed = cnt_failed;
        return r;
    endfunction

    function automatic field_set_t fields_of(result_t r);
        field_set_t f;
        f[0] = {29'd0, r.verdict};
        f[1] = {31'd0, r.payload_valid};
        f[2] = {25'd0, r.payload_index};
        f[3] = r.payload_data;
        f[4] = r.write_addr;
        f[5] = r.write_len;
        f[6] = {16'd0, r.count_accepted};
        f[7] = {16'd0, r.count_rejected};
        f[8] = {16'd0, r.count_ignored};
        f[9] = {16'd0, r.count_flashed};
        f[10] = {16'd0, r.count_failed};
        return f;
    endfunction

    function automatic string field_name(int idx);
        case (idx)
            0:       return "verdict";
            1:       return "payload_valid";
            2:       return "payload_index";
            3:       return "payload_data";
            4:       return "write_addr";
            5:       return "write_len";
            6:       return "count_accepted";
            7:       return "count_rejected";
            8:       return "count_ignored";
            9:       return "count_flashed";
            default: return "count_failed";
        endcase
    endfunction

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Mostly the good value; otherwise a one-bit miss or a random word.
    function automatic logic [31:0] corrupt_some(logic [31:0] good, int unsigned pct);
        if ($urandom_range(0, 99) >= pct)
            return good;
        if ($urandom_range(0, 1) == 1)
            return good ^ (32'd1 << $urandom_range(0, 31));
        return $urandom;
    endfunction

    // Sector address: bounds of the data area, inside it, or anything at all.
    function automatic logic [15:0] pick_addr();
        int area_lo;
        int pick;
        area_lo = 2 + (sectors_cfg >> 8);
        case ($urandom_range(0, 9))
            0:       pick = area_lo - 1;
            1:       pick = area_lo;
            2:       pick = sectors_cfg - 1;
            3:       pick = sectors_cfg;
            4, 5:    pick = $urandom_range(0, 65535);
            default: pick = (area_lo < sectors_cfg) ?
                            $urandom_range(area_lo, sectors_cfg - 1) : $urandom_range(0, 65535);
        endcase
        return pick[15:0];
    endfunction

    // Drives one item from a falling edge, waits for the handshake, and queues
    // its expected result. Leaves s_tvalid high so back-to-back items need no gap.
    task automatic send_item(input sector_item_t it);
        int unsigned gap;
        result_t     want;
        if ($urandom_range(0, 24) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 10);
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser = it.cmd;
        s_tdata = {it.ok, it.word, it.pos, it.addr};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        want = classify_item(it);
        if (it.has_verdict)
            want.verdict = it.verdict;
        pending_results.push_back(want);
        items_sent++;
    endtask

    task automatic send_word(input logic [6:0] pos, input logic [31:0] word,
                             input logic [15:0] addr);
        send_item(make_item(CMD_WORD, addr, pos, word, 1'($urandom_range(0, 1)), NO_CHECK,
                            VERDICT_TAKEN));
    endtask

    // Stops sending and waits until every queued result has come back.
    task automatic drain_items();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_disk_size(input logic [15:0] value);
        drain_items();
        @(negedge aclk);
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        sectors_cfg = value;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // A sector with random content: header words (a few missing now and then),
    // a handful of payload words or the full set, the end word, maybe a flash item.
    task automatic send_sector(input bit full);
        logic [15:0] addr;
        logic [31:0] word;
        int          p;
        int unsigned n;
        addr = pick_addr();
        send_word(POS_START_A, corrupt_some(MAGIC_START_A, 8), addr);
        send_word(POS_START_B, corrupt_some(MAGIC_START_B, 8),
                  16'($urandom_range(0, 65535)));
        for (p = 2; p < 8; p++) begin
            if ($urandom_range(0, 15) != 0) begin
                if (p == POS_FLAGS)
                    word = corrupt_some(FLAGS_EXPECTED, 10);
                else if (p == POS_FAMILY)
                    word = corrupt_some(FAMILY_EXPECTED, 10);
                else
                    word = $urandom;
                send_word(p[6:0], word, 16'($urandom_range(0, 65535)));
            end
        end
        if (full) begin
            for (p = 8; p < 127; p++)
                send_word(p[6:0], $urandom, 16'($urandom_range(0, 65535)));
        end else begin
            n = $urandom_range(0, 6);
            repeat (n)
                send_word(7'($urandom_range(8, 126)), $urandom,
                          16'($urandom_range(0, 65535)));
        end
        send_word(POS_LAST, corrupt_some(MAGIC_FINAL, 8), 16'($urandom_range(0, 65535)));
        if ($urandom_range(0, 9) < 6)
            send_item(make_item(CMD_FLASH, 16'($urandom_range(0, 65535)),
                                7'($urandom_range(0, 127)), $urandom,
                                1'($urandom_range(0, 1)), NO_CHECK, VERDICT_TAKEN));
    endtask

    // Result side: random stall per item, check at the accepting rising edge.
    always begin : result_monitor
        int unsigned stall;
        result_t     want;
        field_set_t  got;
        field_set_t  exp_fields;
        @(negedge aclk);
        if ($urandom_range(0, 24) == 0)
            recv_steady = !recv_steady;
        stall = recv_steady ? 0 : $urandom_range(0, 10);
        if (stall != 0) begin
            m_tready = 1'b0;
            repeat (stall) @(negedge aclk);
        end
        m_tready = 1'b1;
        do @(posedge aclk); while (!m_tvalid);
        got[0] = {29'd0, m_tuser[2:0]};
        got[1] = {31'd0, m_tdata[0]};
        got[2] = {25'd0, m_tdata[7:1]};
        got[3] = m_tdata[39:8];
        got[4] = m_tdata[71:40];
        got[5] = m_tdata[103:72];
        got[6] = {16'd0, m_tdata[119:104]};
        got[7] = {16'd0, m_tdata[135:120]};
        got[8] = {16'd0, m_tdata[151:136]};
        got[9] = {16'd0, m_tdata[167:152]};
        got[10] = {16'd0, m_tdata[183:168]};
        if (pending_results.size() == 0) begin
            report_error($sformatf("result with no item outstanding, verdict %0d", got[0]));
        end else begin
            want = pending_results.pop_front();
            exp_fields = fields_of(want);
            results_checked++;
            case (want.verdict)
                VERDICT_ACCEPTED: seen_accepted++;
                VERDICT_REJECTED: seen_rejected++;
                VERDICT_IGNORED:  seen_ignored++;
                VERDICT_FLASHED, VERDICT_FAILED: seen_flash++;
                default: ;
            endcase
            for (int i = 0; i < 11; i++) begin
                if (got[i] !== exp_fields[i])
                    report_error($sformatf("result %0d: %s is %h, expected %h",
                                           results_checked, field_name(i), got[i],
                                           exp_fields[i]));
            end
            if (m_tuser[7:3] !== 5'd0)
                report_error($sformatf("result %0d: tuser pad is %h", results_checked,
                                       m_tuser[7:3]));
        end
    end

    initial begin
        sector_item_t directed_rows [$];
        logic [15:0]  disk_sizes [NUM_PHASES];
        int unsigned  phase_start;
        int unsigned  choice;
        int unsigned  full_sectors;
        int unsigned  wait_cycles;

        // disk size 8192 after reset: data area is sectors 34 to 8191
        directed_rows = '{
            make_item(CMD_FLASH, 16'd0,     7'd0,        32'd0,          1'b1, CHECK,
                      VERDICT_FLASHED),
            make_item(CMD_FLASH, 16'hFFFF,  7'd127,      32'hFFFFFFFF,   1'b0, CHECK,
                      VERDICT_FAILED),
            // end word straight after reset: start magic never seen
            make_item(CMD_WORD,  16'd0,     POS_LAST,    MAGIC_FINAL,    1'b0, CHECK,
                      VERDICT_IGNORED),
            // good sector at the low edge of the data area, extreme header values
            make_item(CMD_WORD,  16'd34,    POS_START_A, MAGIC_START_A,  1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     POS_START_B, MAGIC_START_B,  1'b1, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     POS_FLAGS,   FLAGS_EXPECTED, 1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     POS_TARGET,  32'hFFFFFFFF,   1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     POS_SIZE,    32'hFFFFFFFF,   1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     7'd5,        32'd0,          1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     7'd6,        32'hFFFFFFFF,   1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     POS_FAMILY,  FAMILY_EXPECTED, 1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            // first and last payload words; address is don't-care here
            make_item(CMD_WORD,  16'hFFFF,  POS_PAYLOAD, 32'hFFFFFFFF,   1'b1, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     7'd126,      32'd0,          1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     POS_LAST,    MAGIC_FINAL,    1'b0, CHECK,
                      VERDICT_ACCEPTED),
            make_item(CMD_FLASH, 16'd0,     7'd0,        32'd0,          1'b1, CHECK,
                      VERDICT_FLASHED),
            // wrong flags, then wrong family: rejected
            make_item(CMD_WORD,  16'd0,     POS_FLAGS,   32'hFFFFDFFF,   1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     POS_LAST,    MAGIC_FINAL,    1'b0, CHECK,
                      VERDICT_REJECTED),
            make_item(CMD_WORD,  16'd0,     POS_FLAGS,   FLAGS_EXPECTED, 1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     POS_FAMILY,  32'd0,          1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     POS_LAST,    MAGIC_FINAL,    1'b0, CHECK,
                      VERDICT_REJECTED),
            make_item(CMD_WORD,  16'd0,     POS_FAMILY,  FAMILY_EXPECTED, 1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            // top sector of the data area, other header words missing
            make_item(CMD_WORD,  16'd8191,  POS_START_A, MAGIC_START_A,  1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     POS_START_B, MAGIC_START_B,  1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     POS_LAST,    MAGIC_FINAL,    1'b0, CHECK,
                      VERDICT_ACCEPTED),
            // wrong end magic
            make_item(CMD_WORD,  16'd0,     POS_LAST,    32'd0,          1'b0, CHECK,
                      VERDICT_IGNORED),
            // first sector past the data area
            make_item(CMD_WORD,  16'd8192,  POS_START_A, MAGIC_START_A,  1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     POS_START_B, MAGIC_START_B,  1'b0, NO_CHECK,
                      VERDICT_TAKEN),
            make_item(CMD_WORD,  16'd0,     POS_LAST,    MAGIC_FINAL,    1'b0, CHECK,
                      VERDICT_IGNORED)
        };

        // empty area, largest disk, small disk, random, area of zero width, default
        disk_sizes[0] = 16'd0;
        disk_sizes[1] = 16'hFFFF;
        disk_sizes[2] = 16'd300;
        disk_sizes[3] = 16'($urandom_range(0, 65535));
        disk_sizes[4] = 16'd2;
        disk_sizes[5] = DISK_SIZE_RESET;
        full_sectors = 0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i]);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_disk_size(disk_sizes[ph]);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                choice = $urandom_range(0, 9);
                if (choice == 0) begin
                    // noise: stray words in any position and flash reports
                    repeat ($urandom_range(1, 5))
                        send_item(make_item($urandom_range(0, 3) == 0,
                                            16'($urandom_range(0, 65535)),
                                            7'($urandom_range(0, 127)),
                                            $urandom, 1'($urandom_range(0, 1)), NO_CHECK,
                                            VERDICT_TAKEN));
                end else begin
                    if (choice == 1)
                        drain_items();
                    if (full_sectors < 2 && $urandom_range(0, 29) == 0) begin
                        full_sectors++;
                        send_sector(1'b1);
                    end else begin
                        send_sector(1'b0);
                    end
                end
            end
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        wait_cycles = 0;
        while (pending_results.size() != 0 && wait_cycles < 5000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (DRAIN_CYCLES + 4) @(posedge aclk);
        if (pending_results.size() != 0)
            report_error($sformatf("%0d results never arrived", pending_results.size()));

        $display("Covered %0d items, %0d results checked over %0d disk sizes;",
                 items_sent, results_checked, cfg_writes);
        $display("sectors accepted %0d, rejected %0d, ignored %0d, flash reports %0d",
                 seen_accepted, seen_rejected, seen_ignored, seen_flash);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
